// ===== src/assert_macros.svh =====
// Assertion macros used by the unpacker RTL; they expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ===== src/tfu_pkg.sv =====
// Types, register map and conversion helpers for the texel format unpacker.
`default_nettype none

package tfu_pkg;

    // Source texel formats held in the format register.
    typedef enum logic [2:0] {
        FMT_RGBA5551 = 3'd0,
        FMT_RGB888   = 3'd1,
        FMT_RGBA8888 = 3'd2,
        FMT_INDEX4   = 3'd3,
        FMT_INDEX8   = 3'd4
    } t_src_fmt;

    // Register indexes, taken from the word address of the configuration port.
    typedef enum logic [1:0] {
        REG_SOURCE_FORMAT = 2'd0,
        REG_ROW_WIDTH     = 2'd1,
        REG_IMAGE_HEIGHT  = 2'd2
    } t_reg_idx;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [2:0]  SOURCE_FORMAT_RST = 3'd0;
    localparam logic [15:0] ROW_WIDTH_RST     = 16'd1;
    localparam logic [15:0] IMAGE_HEIGHT_RST  = 16'd1;

    localparam logic [7:0] CHAN_MAX = 8'hFF;

    // Five-bit channel widened to eight bits by repeating its top bits.
    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    // Half-range alpha rescaled as a*255/128, saturating at full scale.
    function automatic logic [7:0] scale_alpha(input logic [7:0] a);
        logic [15:0] prod;
        prod = {a, 8'd0} - {8'd0, a};
        if (a[7]) begin
            return CHAN_MAX;
        end
        return prod[14:7];
    endfunction

endpackage

`default_nettype wire

// ===== src/texel_format_unpacker_unit.sv =====
// Texel format unpacker: converts raw source texel words into RGBA8888 pixels or palette indices.
//
// Each accepted source word goes into an input register, is converted by short logic and lands
// in an output register. A new word can be taken every cycle while the output side keeps taking
// results. Direct colour formats and index8 give one result per word, so the sustained rate is
// one word per cycle; index4 gives two results per word (low nibble first) through the single
// output register, so the next word waits while the high nibble is shown, unless the low nibble
// closes an odd-width row.
// Words in an unknown format are dropped without a result and without moving the counters.
// The column counter advances once per result and the row counter once per row; they flag the
// end of each row and of the image. Registers: source format at byte address 0, row width at 4,
// image height at 8; a width or height of zero acts as 65536. Configuration must be written
// only while the block is idle; the block itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module texel_format_unpacker_unit
    import tfu_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    // Configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output logic      [DATA_W-1:0]   prdata,
    output logic                     pready,

    // Source word channel
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [31:0]         i_raw_word,

    // Result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic      [7:0]          o_red,
    output logic      [7:0]          o_green,
    output logic      [7:0]          o_blue,
    output logic      [7:0]          o_alpha,
    output logic      [7:0]          o_palette_index,
    output logic                     o_last_of_run,
    output logic                     o_end_of_row,
    output logic                     o_end_of_image
);

    // Configuration registers
    logic [2:0]  r_source_format;
    logic [15:0] r_row_width;
    logic [15:0] r_image_height;

    // Input stage
    logic        r_in_valid;
    logic [31:0] r_in_word;

    // Position counters
    logic [15:0] r_column_count;
    logic [15:0] r_row_count;

    // Deferred high nibble for index4
    logic        r_hi_pending;
    logic [3:0]  r_hi_nibble;

    // Output stage
    logic        r_out_valid;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;
    logic [7:0]  r_alpha;
    logic [7:0]  r_palette_index;
    logic        r_last_of_run;
    logic        r_end_of_row;
    logic        r_end_of_image;

    logic        cfg_write;
    t_reg_idx    cfg_idx;
    logic        in_accept;
    logic        out_free;
    logic        fmt_ok;
    logic        load_hi;
    logic        load_in;
    logic        load;
    logic        in_consume;
    logic        is_index4;

    logic [15:0] col_inc;
    logic [15:0] row_inc;
    logic        eor;
    logic        eoi;

    logic [7:0]  n_red;
    logic [7:0]  n_green;
    logic [7:0]  n_blue;
    logic [7:0]  n_alpha;
    logic [7:0]  n_palette_index;
    logic        n_last_of_run;
    logic        n_hi_pending;
    logic [15:0] n_column_count;
    logic [15:0] n_row_count;

    // ---------------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_idx   = t_reg_idx'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_idx)
            REG_SOURCE_FORMAT: prdata = {29'd0, r_source_format};
            REG_ROW_WIDTH:     prdata = {16'd0, r_row_width};
            REG_IMAGE_HEIGHT:  prdata = {16'd0, r_image_height};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_format <= SOURCE_FORMAT_RST;
            r_row_width     <= ROW_WIDTH_RST;
            r_image_height  <= IMAGE_HEIGHT_RST;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_SOURCE_FORMAT: r_source_format <= pwdata[2:0];
                REG_ROW_WIDTH:     r_row_width     <= pwdata[15:0];
                REG_IMAGE_HEIGHT:  r_image_height  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Flow control
    // ---------------------------------------------------------------------
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        case (r_source_format)
            FMT_RGBA5551,
            FMT_RGB888,
            FMT_RGBA8888,
            FMT_INDEX4,
            FMT_INDEX8: fmt_ok = 1'b1;
            default:    fmt_ok = 1'b0;
        endcase
    end

    assign is_index4  = (r_source_format == FMT_INDEX4);
    assign load_hi    = r_hi_pending && out_free;
    assign load_in    = !r_hi_pending && r_in_valid && fmt_ok && out_free;
    assign load       = load_hi || load_in;
    // A word in an unknown format leaves the input stage without producing anything.
    assign in_consume = !r_hi_pending && r_in_valid && (out_free || !fmt_ok);
    assign o_in_stall = r_in_valid && !in_consume;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (in_consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_word <= i_raw_word;
        end
    end

    // ---------------------------------------------------------------------
    // Position counters: one step for every result loaded
    // ---------------------------------------------------------------------
    assign col_inc = r_column_count + 16'd1;
    assign row_inc = r_row_count + 16'd1;
    assign eor     = (col_inc == r_row_width);
    assign eoi     = eor && (row_inc == r_image_height);

    always_comb begin
        n_column_count = eor ? 16'd0 : col_inc;
        n_row_count    = r_row_count;
        if (eor) begin
            n_row_count = eoi ? 16'd0 : row_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count <= '0;
            r_row_count    <= '0;
        end else if (load) begin
            r_column_count <= n_column_count;
            r_row_count    <= n_row_count;
        end
    end

    // ---------------------------------------------------------------------
    // Conversion
    // ---------------------------------------------------------------------
    always_comb begin
        n_red           = 8'd0;
        n_green         = 8'd0;
        n_blue          = 8'd0;
        n_alpha         = 8'd0;
        n_palette_index = 8'd0;
        n_last_of_run   = 1'b1;
        n_hi_pending    = 1'b0;
        if (r_hi_pending) begin
            n_palette_index = {4'd0, r_hi_nibble};
        end else begin
            case (r_source_format)
                FMT_RGBA5551: begin
                    n_red   = widen5(r_in_word[4:0]);
                    n_green = widen5(r_in_word[9:5]);
                    n_blue  = widen5(r_in_word[14:10]);
                    n_alpha = r_in_word[15] ? CHAN_MAX : 8'd0;
                end
                FMT_RGB888: begin
                    n_red   = r_in_word[7:0];
                    n_green = r_in_word[15:8];
                    n_blue  = r_in_word[23:16];
                    n_alpha = CHAN_MAX;
                end
                FMT_RGBA8888: begin
                    n_red   = r_in_word[7:0];
                    n_green = r_in_word[15:8];
                    n_blue  = r_in_word[23:16];
                    n_alpha = scale_alpha(r_in_word[31:24]);
                end
                FMT_INDEX4: begin
                    // The high nibble follows unless the low one closes the row.
                    n_palette_index = {4'd0, r_in_word[3:0]};
                    n_hi_pending    = !eor;
                    n_last_of_run   = eor;
                end
                FMT_INDEX8: begin
                    n_palette_index = r_in_word[7:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi_pending <= 1'b0;
        end else if (load) begin
            r_hi_pending <= n_hi_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in && is_index4) begin
            r_hi_nibble <= r_in_word[7:4];
        end
    end

    // ---------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_red           <= n_red;
            r_green         <= n_green;
            r_blue          <= n_blue;
            r_alpha         <= n_alpha;
            r_palette_index <= n_palette_index;
            r_last_of_run   <= n_last_of_run;
            r_end_of_row    <= eor;
            r_end_of_image  <= eoi;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_red           = r_red;
    assign o_green         = r_green;
    assign o_blue          = r_blue;
    assign o_alpha         = r_alpha;
    assign o_palette_index = r_palette_index;
    assign o_last_of_run   = r_last_of_run;
    assign o_end_of_row    = r_end_of_row;
    assign o_end_of_image  = r_end_of_image;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `ASSERT_PROP(a_hi_needs_low_shown, i_clk, i_rst_n, r_hi_pending |-> r_out_valid, "high nibble pending without a result on show")
    `ASSERT_PROP(a_hi_follows, i_clk, i_rst_n, r_hi_pending && !i_out_stall |=> o_out_valid && o_last_of_run && !r_hi_pending, "high nibble did not follow the low one")
    `ASSERT_PROP(a_not_last_means_more, i_clk, i_rst_n, o_out_valid && !o_last_of_run |-> r_hi_pending, "result not last of its run but nothing pending")
    `ASSERT_PROP(a_eoi_ends_row, i_clk, i_rst_n, o_out_valid && o_end_of_image |-> o_end_of_row, "end of image without end of row")
    `ASSERT_NEVER(a_no_take_while_hi, i_clk, i_rst_n, in_consume && r_hi_pending, "source word consumed while a high nibble is pending")

endmodule

`default_nettype wire

// ===== bench/texel_format_unpacker_unit_tb.sv =====
// Self-checking testbench for the texel format unpacker: directed and random texel streams.
`timescale 1ns / 100ps

module texel_format_unpacker_unit_tb;
    import tfu_pkg::*;

    localparam logic [2:0] FMT_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] FMT_RESERVED_LAST  = 3'd7;
    localparam int RANDOM_ITEMS  = 1700;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_OFF      = 300;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] palette_index;
        logic       last_of_run;
        logic       end_of_row;
        logic       end_of_image;
    } t_pixel;

    class texel_scoreboard;
        logic [2:0]  fmt;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] column;
        logic [15:0] row;
        t_pixel      expected_pixels[$];
        int          errors;

        function new();
            fmt    = SOURCE_FORMAT_RST;
            width  = ROW_WIDTH_RST;
            height = IMAGE_HEIGHT_RST;
            column = '0;
            row    = '0;
            errors = 0;
        endfunction

        function void set_register(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_SOURCE_FORMAT: fmt = value[2:0];
                REG_ROW_WIDTH:     width = value[15:0];
                REG_IMAGE_HEIGHT:  height = value[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function logic [7:0] widen_channel(logic [4:0] v);
            return {v, 3'b000} | {5'b00000, v[4:2]};
        endfunction

        function logic [7:0] half_alpha(logic [7:0] a);
            int unsigned scaled;
            scaled = int'(a) * 255 / 128;
            return (scaled > 255) ? 8'hFF : scaled[7:0];
        endfunction

        // Builds one pixel and moves the column and row counters past it.
        function t_pixel place_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic [7:0] a, logic [7:0] idx);
            t_pixel      p;
            logic [15:0] col;
            p               = '0;
            p.red           = r;
            p.green         = g;
            p.blue          = b;
            p.alpha         = a;
            p.palette_index = idx;
            col = column + 16'd1;
            if (col == width) begin
                p.end_of_row = 1'b1;
                col = '0;
                row = row + 16'd1;
                if (row == height) begin
                    p.end_of_image = 1'b1;
                    row = '0;
                end
            end
            column = col;
            return p;
        endfunction

        function void note_word(logic [31:0] w);
            t_pixel p;
            case (fmt)
                FMT_RGBA5551: p = place_pixel(widen_channel(w[4:0]), widen_channel(w[9:5]),
                                              widen_channel(w[14:10]),
                                              w[15] ? 8'hFF : 8'h00, 8'h00);
                FMT_RGB888:   p = place_pixel(w[7:0], w[15:8], w[23:16], 8'hFF, 8'h00);
                FMT_RGBA8888: p = place_pixel(w[7:0], w[15:8], w[23:16],
                                              half_alpha(w[31:24]), 8'h00);
                FMT_INDEX4: begin
                    p = place_pixel(8'h00, 8'h00, 8'h00, 8'h00, {4'h0, w[3:0]});
                    // When the low nibble closes a row of odd width, the high one is dropped.
                    if (!p.end_of_row) begin
                        expected_pixels.push_back(p);
                        p = place_pixel(8'h00, 8'h00, 8'h00, 8'h00, {4'h0, w[7:4]});
                    end
                end
                FMT_INDEX8:   p = place_pixel(8'h00, 8'h00, 8'h00, 8'h00, w[7:0]);
                default: return;
            endcase
            p.last_of_run = 1'b1;
            expected_pixels.push_back(p);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_pixel got);
            t_pixel want;
            if (expected_pixels.size() == 0) begin
                $error("unexpected result: palette_index %0d red %0d alpha %0d",
                       got.palette_index, got.red, got.alpha);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
            compare_field("alpha", want.alpha, got.alpha);
            compare_field("palette_index", want.palette_index, got.palette_index);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
            compare_field("end_of_row", want.end_of_row, got.end_of_row);
            compare_field("end_of_image", want.end_of_image, got.end_of_image);
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [31:0]       raw_word = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic [7:0]        palette_index;
    logic              last_of_run;
    logic              end_of_row;
    logic              end_of_image;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_cycles = 0;

    texel_scoreboard sb = new();

    texel_format_unpacker_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_raw_word      (raw_word),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_red           (red),
        .o_green         (green),
        .o_blue          (blue),
        .o_alpha         (alpha),
        .o_palette_index (palette_index),
        .o_last_of_run   (last_of_run),
        .o_end_of_row    (end_of_row),
        .o_end_of_image  (end_of_image)
    );

    always #4 clk = ~clk;

    // The receiver stalls at random, or for a counted stretch when a hold-off is asked for.
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            out_stall = 1'b1;
            hold_cycles = hold_cycles - 1;
        end else begin
            out_stall = ($urandom_range(99) < sink_stall_pct);
        end
    end

    always @(posedge clk) begin : result_check
        t_pixel got;
        if (rst_n && out_valid && !out_stall) begin
            got.red           = red;
            got.green         = green;
            got.blue          = blue;
            got.alpha         = alpha;
            got.palette_index = palette_index;
            got.last_of_run   = last_of_run;
            got.end_of_row    = end_of_row;
            got.end_of_image  = end_of_image;
            sb.check_result(got);
        end
    end

    // Unused upper data bits carry random junk, which the block must ignore.
    task automatic write_reg(input t_reg_idx idx, input logic [15:0] value);
        logic [31:0] word;
        word = $urandom();
        if (idx == REG_SOURCE_FORMAT) begin
            word[2:0] = value[2:0];
        end else begin
            word[15:0] = value;
        end
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = word;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_register(idx, word);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic configure(input logic [2:0] fmt, input logic [15:0] width,
                             input logic [15:0] height);
        settle();
        write_reg(REG_SOURCE_FORMAT, {13'd0, fmt});
        write_reg(REG_ROW_WIDTH, width);
        write_reg(REG_IMAGE_HEIGHT, height);
    endtask

    task automatic send_word(input logic [31:0] word);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid = 1'b0;
            raw_word = $urandom();
            @(negedge clk);
        end
        in_valid = 1'b1;
        raw_word = word;
        do @(posedge clk); while (in_stall);
        sb.note_word(word);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Mostly small extents, so that row and image ends come often.
    function automatic logic [15:0] pick_extent(input int most);
        case ($urandom_range(9))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            2:       return 16'd0;
            3:       return 16'($urandom_range(65535, 1));
            default: return 16'($urandom_range(most, 1));
        endcase
    endfunction

    initial begin
        int         items_done;
        int         phase;
        int         count;
        logic [2:0] fmt;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        configure(FMT_RGBA5551, 16'd3, 16'd2);
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_8000);
        send_word(32'h0000_7C1F);

        configure(FMT_RGB888, 16'd1, 16'hFFFF);
        send_word(32'h00FF_FFFF);
        send_word(32'hFF00_0000);
        send_word(32'h1234_5678);

        // Alpha around the saturation point of the half-range scaling.
        configure(FMT_RGBA8888, 16'd2, 16'd1);
        send_word(32'h00A1_B2C3);
        send_word(32'h7F10_2030);
        send_word(32'h80FF_00FF);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0100_0000);

        // Odd row width: every second word loses its high nibble at the row end.
        configure(FMT_INDEX4, 16'd3, 16'd1);
        send_word(32'h0000_00A5);
        send_word(32'h0000_005A);
        send_word(32'hFFFF_FF0F);
        send_word(32'h0000_00F0);

        configure(FMT_INDEX8, 16'hFFFF, 16'd0);
        send_word(32'h0000_0000);
        send_word(32'h0000_00FF);
        send_word(32'hFFFF_FF80);

        // Words in a reserved format are taken but give nothing.
        for (int f = FMT_RESERVED_FIRST; f <= FMT_RESERVED_LAST; f++) begin
            configure(3'(f), 16'd2, 16'd2);
            send_word($urandom());
        end

        items_done = 0;
        phase = 0;
        while (items_done < RANDOM_ITEMS) begin
            if ($urandom_range(11) == 0) begin
                fmt = 3'($urandom_range(FMT_RESERVED_LAST, FMT_RESERVED_FIRST));
            end else begin
                fmt = 3'($urandom_range(FMT_INDEX8, FMT_RGBA5551));
            end
            if (phase == 2) begin
                fmt = FMT_INDEX4;
            end
            configure(fmt, pick_extent(8), pick_extent(5));
            case (phase % 4)
                0: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 60;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    sink_stall_pct = 60;
                end
                default: begin
                    src_idle_pct = 16;
                    sink_stall_pct = 16;
                end
            endcase
            // The receiver holds off while words keep coming, so the block backs up.
            if (phase == 2) begin
                hold_cycles = HOLD_OFF;
            end
            count = $urandom_range(120, 40);
            repeat (count) send_word(pick_word());
            if (fmt <= FMT_INDEX8) begin
                items_done += count;
            end
            phase++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
